// File: src/lkv_pkg.sv
package lkv_pkg;

    // store geometry
    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_W = 4;

    // limit register reset value
    localparam logic [CFG_W-1:0] LIMIT_RESET = 4'd8;

    // command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // one stored entry as it moves along the chain
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } lkv_entry_t;

    // per-cell control
    typedef struct packed {
        logic capture;  // latch the key compare result
        logic load;     // take the entry from the neighbor before it
    } lkv_ctl_t;

endpackage

// File: src/lru_key_value_cache_top.sv
// Fully associative key-value cache with least-recently-used replacement.
// Input channel s_*: one request per beat, s_tuser = command (get or put),
// s_tdata = lookup_key and write_value. Result channel m_*: one result per
// request, m_tuser = hit, m_tdata = read_value (zero on a miss and on a put).
// Entries sit in a chain of cells ordered by recency, cell 0 the most recent.
// A request runs as follows: on the accepting edge every cell compares its key
// with the request key; once the output register is free, the touched or
// inserted entry moves to cell 0 while the cells in front of it shift back by
// one, and the result is registered. A new request is taken only after this
// compare-then-shift sequence through the cell chain has finished.
// A finished result may wait in the output register while the next request
// is accepted and compared; that request completes only once the output
// register is free, so a stalled receiver holds the block after one request.
// cfg_wr_en / cfg_wr_data set the number of entries held before eviction
// (0 acts as 1, above the capacity acts as the capacity); write only while
// idle. Synchronous reset empties the cache and sets the limit to 8.
module lru_key_value_cache_top (
    input  logic        aclk,
    input  logic        aresetn,
    // config
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic        s_tuser,   // [0] command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] read_value
    output logic        m_tuser    // [0] hit
);
    import lkv_pkg::*;

    localparam int WIDE_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0] limit_reg, limit_next;
    logic             busy_reg, busy_next;
    logic             req_cmd_reg;
    logic [KEY_W-1:0] req_key_reg;
    logic [VAL_W-1:0] req_val_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_hit_reg, out_hit_next;
    logic [VAL_W-1:0] out_value_reg, out_value_next;

    logic             accept;
    logic             apply;
    logic             any_hit;
    logic [VAL_W-1:0] hit_value;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] target;
    logic             full;
    logic             do_shift;
    logic [WIDE_W-1:0] lim_wide;
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] valid_vec;

    lkv_entry_t entry_chain [CAPACITY+1];
    lkv_ctl_t   cell_ctl    [CAPACITY];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg;
    assign apply    = busy_reg && (!out_valid_reg || m_tready);

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [IDX_W-1:0] CI = IDX_W'(i);
        assign cell_ctl[i].capture = accept;
        assign cell_ctl[i].load    = apply && do_shift && (CI <= target);
        assign valid_vec[i]        = entry_chain[i+1].valid;

        lkv_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmp_key    (s_tdata[KEY_W-1:0]),
            .ctl        (cell_ctl[i]),
            .prev_entry (entry_chain[i]),
            .entry      (entry_chain[i+1]),
            .match      (match_vec[i])
        );
    end

    // hit detection and value select
    always_comb begin
        any_hit   = 1'b0;
        hit_value = '0;
        hit_idx   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (match_vec[i]) begin
                any_hit   = 1'b1;
                hit_value = hit_value | entry_chain[i+1].value;
                hit_idx   = hit_idx | IDX_W'(i);
            end
        end
    end

    // effective limit and fullness
    always_comb begin
        lim_wide = WIDE_W'(limit_reg);
        if (limit_reg == '0) begin
            lim_wide = WIDE_W'(1);
        end
        if (lim_wide > WIDE_W'(CAPACITY)) begin
            lim_wide = WIDE_W'(CAPACITY);
        end
        full = WIDE_W'(count_reg) >= lim_wide;
    end

    // target cell: the hit, the least recent when full, else the first free
    always_comb begin
        if (any_hit) begin
            target = hit_idx;
        end else if (full) begin
            target = IDX_W'(count_reg - 1'b1);
        end else begin
            target = IDX_W'(count_reg);
        end
        do_shift = any_hit || (req_cmd_reg == CMD_PUT);
    end

    // entry entering the front of the chain
    always_comb begin
        entry_chain[0].valid = 1'b1;
        entry_chain[0].key   = req_key_reg;
        entry_chain[0].value = (req_cmd_reg == CMD_PUT) ? req_val_reg : hit_value;
    end

    // control next state
    always_comb begin
        limit_next     = limit_reg;
        busy_next      = busy_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_value_next = out_value_reg;
        if (cfg_wr_en) begin
            limit_next = cfg_wr_data;
        end
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
        end
        if (apply) begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            out_hit_next   = any_hit;
            out_value_next = (any_hit && req_cmd_reg == CMD_GET) ? hit_value : '0;
            if (!any_hit && req_cmd_reg == CMD_PUT && !full) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= LIMIT_RESET;
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            limit_reg     <= limit_next;
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_cmd_reg <= s_tuser;
            req_key_reg <= s_tdata[KEY_W-1:0];
            req_val_reg <= s_tdata[KEY_W+VAL_W-1:KEY_W];
        end
        out_hit_reg   <= out_hit_next;
        out_value_reg <= out_value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = out_value_reg;

    // valid cells form a solid run from the front and match the count
    a_valid_run : assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(valid_vec) == int'(count_reg)) &&
        ((valid_vec & (valid_vec + 1'b1)) == '0))
        else $error("valid cells do not match the fill count");

    // count never passes the capacity
    a_count_max : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // keys are unique, so at most one cell matches
    a_match_one : assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> $onehot0(match_vec))
        else $error("more than one cell matched the request key");

    // a put leaves its key in the front cell
    a_put_front : assert property (@(posedge aclk) disable iff (!aresetn)
        (apply && req_cmd_reg == CMD_PUT) |=>
        (entry_chain[1].valid && entry_chain[1].key == $past(req_key_reg)))
        else $error("put key missing from the front cell");

    // a request is finished before the next is taken
    a_one_inflight : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (busy_reg && !s_tready))
        else $error("request taken while another is in flight");

endmodule

// File: src/lkv_cell.sv
module lkv_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [lkv_pkg::KEY_W-1:0] cmp_key,
    input  lkv_pkg::lkv_ctl_t        ctl,
    input  lkv_pkg::lkv_entry_t      prev_entry,
    output lkv_pkg::lkv_entry_t      entry,
    output logic                     match
);
    import lkv_pkg::*;

    lkv_entry_t entry_reg;
    lkv_entry_t entry_next;
    logic       match_reg;
    logic       match_next;

    // key compare, latched when a request is taken
    always_comb begin
        match_next = match_reg;
        if (ctl.capture) begin
            match_next = entry_reg.valid && (entry_reg.key == cmp_key);
        end
    end

    // shift in the neighbor's entry
    always_comb begin
        entry_next = entry_reg;
        if (ctl.load) begin
            entry_next = prev_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
            match_reg       <= 1'b0;
        end else begin
            entry_reg <= entry_next;
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule
